// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, reset values, register indexes and the item record used
// by the pre-trigger threshold capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W   = 12;
   localparam int COUNT_W    = 24;

   // Stream widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POST_COUNT = 1'd1;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 12'd3500;
   localparam logic [COUNT_W-1:0]  POST_COUNT_RESET = 24'd10000000;

   // One triggered request as handed from the control unit to the output unit
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                has_pre;
      logic [COUNT_W-1:0]  pre_pos;
      logic [COUNT_W-1:0]  seq;
      logic                done;
   } ptc_item_type;

endpackage

`default_nettype wire

// ===== rtl/ptc_ram.sv =====
// ----------------------------------------------------------------------------
// ptc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptc_ctrl
// Configuration registers, ring pointers, fill level, trigger flag and live
// counter. Decides per request whether it is stored or triggers results.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration writes
   input  wire logic                             csr_write,
   input  wire logic [ptc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ptc_pkg::CSR_DATA_W-1:0]   csr_data,
   // accepted request
   input  wire logic                             accept,
   input  wire logic [ptc_pkg::SAMPLE_W-1:0]     sample,
   // ring access
   output      logic                             ram_wr_en,
   output      logic [ptc_pkg::ADDR_W-1:0]       ram_wr_addr,
   output      logic [ptc_pkg::SAMPLE_W-1:0]     ram_wr_data,
   output      logic                             ram_rd_en,
   output      logic [ptc_pkg::ADDR_W-1:0]       ram_rd_addr,
   // triggered request toward the output unit
   output      logic                             push,
   output      ptc_pkg::ptc_item_type            item
);

   logic [ptc_pkg::SAMPLE_W-1:0] threshold_ff, threshold_in;
   logic [ptc_pkg::COUNT_W-1:0]  post_count_ff, post_count_in;
   logic [ptc_pkg::ADDR_W-1:0]   write_ptr_ff, write_ptr_in;
   logic [ptc_pkg::ADDR_W-1:0]   oldest_ptr_ff, oldest_ptr_in;
   logic [ptc_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                         trig_ff, trig_in;
   logic [ptc_pkg::COUNT_W-1:0]  live_ff, live_in;

   logic                         store;
   logic                         has_pre;
   logic                         ring_full;
   logic [ptc_pkg::COUNT_W-1:0]  live_next;
   logic                         done;

   function automatic logic [ptc_pkg::ADDR_W-1:0] next_slot(
      input logic [ptc_pkg::ADDR_W-1:0] p
   );
      logic [ptc_pkg::ADDR_W-1:0] r;
      if (p == ptc_pkg::ADDR_W'(ptc_pkg::RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Classify the request
   assign store     = !trig_ff && (sample <= threshold_ff);
   assign has_pre   = (fill_ff != '0);
   assign ring_full = (fill_ff == ptc_pkg::FILL_W'(ptc_pkg::RING_DEPTH));
   assign live_next = live_ff + 1'b1;
   assign done      = (live_next == post_count_ff);

   // Ring access
   assign ram_wr_en   = accept && store;
   assign ram_wr_addr = write_ptr_ff;
   assign ram_wr_data = sample;
   assign ram_rd_en   = accept && !store && has_pre;
   assign ram_rd_addr = oldest_ptr_ff;

   // Hand a triggered request to the output unit
   assign push         = accept && !store;
   assign item.sample  = sample;
   assign item.has_pre = has_pre;
   assign item.pre_pos = ptc_pkg::COUNT_W'(oldest_ptr_ff);
   assign item.seq     = live_ff;
   assign item.done    = done;

   // Configuration registers
   always_comb begin
      threshold_in  = threshold_ff;
      post_count_in = post_count_ff;
      if (csr_write) begin
         case (csr_index)
            ptc_pkg::REG_THRESHOLD: begin
               threshold_in = csr_data[ptc_pkg::SAMPLE_W-1:0];
            end
            ptc_pkg::REG_POST_COUNT: begin
               post_count_in = csr_data;
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   // Advance ring pointers, fill level, trigger and live count
   always_comb begin
      write_ptr_in  = write_ptr_ff;
      oldest_ptr_in = oldest_ptr_ff;
      fill_in       = fill_ff;
      trig_in       = trig_ff;
      live_in       = live_ff;
      if (accept) begin
         if (store) begin
            write_ptr_in = next_slot(write_ptr_ff);
            if (ring_full) begin
               oldest_ptr_in = next_slot(oldest_ptr_ff);
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end else begin
            if (has_pre) begin
               oldest_ptr_in = next_slot(oldest_ptr_ff);
               fill_in       = fill_ff - 1'b1;
            end
            if (done) begin
               live_in = '0;
               trig_in = 1'b0;
            end else begin
               live_in = live_next;
               trig_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= ptc_pkg::THRESHOLD_RESET;
         post_count_ff <= ptc_pkg::POST_COUNT_RESET;
         write_ptr_ff  <= '0;
         oldest_ptr_ff <= '0;
         fill_ff       <= '0;
         trig_ff       <= 1'b0;
         live_ff       <= '0;
      end else begin
         threshold_ff  <= threshold_in;
         post_count_ff <= post_count_in;
         write_ptr_ff  <= write_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         fill_ff       <= fill_in;
         trig_ff       <= trig_in;
         live_ff       <= live_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ptc_out.sv =====
// ----------------------------------------------------------------------------
// ptc_out
// Holds one triggered request and emits its results, the drained stored
// sample first and the live sample second, through the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_out (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire ptc_pkg::ptc_item_type             item,
   input  wire logic [ptc_pkg::SAMPLE_W-1:0]      ram_rd_data,
   output      logic                              slot_free,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ptc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // value_out, position
   output      logic [ptc_pkg::RSP_TUSER_W-1:0]   rsp_tuser,  // kind, capture_done
   output      logic                              rsp_tlast
);

   localparam int PAD_W = ptc_pkg::RSP_TDATA_W - ptc_pkg::SAMPLE_W - ptc_pkg::COUNT_W;

   // Pending request
   logic                            hold_valid_ff, hold_valid_in;
   logic                            hold_pre_ff, hold_pre_in;
   ptc_pkg::ptc_item_type           hold_ff, hold_in;

   // Result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ptc_pkg::SAMPLE_W-1:0]    value_ff, value_in;
   logic                            kind_ff, kind_in;
   logic [ptc_pkg::COUNT_W-1:0]     pos_ff, pos_in;
   logic                            done_ff, done_in;
   logic                            last_ff, last_in;

   logic                            out_open;
   logic                            load;

   assign out_open  = !rsp_valid_ff || rsp_tready;
   assign load      = hold_valid_ff && out_open;
   assign slot_free = !hold_valid_ff || (load && !hold_pre_ff);

   // Hold or retire the pending request
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_pre_in   = hold_pre_ff;
      hold_in       = hold_ff;
      if (push) begin
         hold_valid_in = 1'b1;
         hold_pre_in   = item.has_pre;
         hold_in       = item;
      end else if (load) begin
         if (hold_pre_ff) begin
            hold_pre_in = 1'b0;
         end else begin
            hold_valid_in = 1'b0;
         end
      end
   end

   // Load the next result, or drop the one taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (hold_pre_ff) begin
            value_in = ram_rd_data;
            kind_in  = 1'b0;
            pos_in   = hold_ff.pre_pos;
            done_in  = 1'b0;
            last_in  = 1'b0;
         end else begin
            value_in = hold_ff.sample;
            kind_in  = 1'b1;
            pos_in   = hold_ff.seq;
            done_in  = hold_ff.done;
            last_in  = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_pre_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_pre_ff   <= hold_pre_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      value_ff <= value_in;
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      done_ff  <= done_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, pos_ff, value_ff};
   assign rsp_tuser  = {done_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/pretrigger_threshold_capture.sv =====
// ----------------------------------------------------------------------------
// pretrigger_threshold_capture
// Stores samples at or below a threshold in a pre-trigger ring; a sample
// above it starts a capture that drains the ring alongside live samples.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------
//  req      | in  | req_tvalid/req_tready | tdata: sample_value[11:0]
//  rsp      | out | rsp_tvalid/rsp_tready | tdata: value_out[11:0], position[35:12]
//           |     |                       | tuser: kind[0], capture_done[1]
//           |     |                       | tlast: last_of_run
//  csr      | in  | csr_valid/csr_ready   | csr_index, csr_data
//
//  A stored sample only writes the ring; a triggered sample gives one result,
//  or two while the ring drains, through the single result register, which
//  emits one result per cycle when rsp is not stalled.
//  Reset clears pointers, fill level, trigger and live count; the ring itself
//  is not cleared, since only entries counted in the fill level are read.
//  A stall on rsp holds the result register and, once the pending request
//  is also blocked, deasserts req_tready. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pretrigger_threshold_capture (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [ptc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // sample_value[11:0]
   // result stream
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ptc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // value_out, position
   output      logic [ptc_pkg::RSP_TUSER_W-1:0]   rsp_tuser,  // kind, capture_done
   output      logic                              rsp_tlast,
   // configuration writes
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [ptc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ptc_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                            accept;
   logic                            ram_wr_en;
   logic [ptc_pkg::ADDR_W-1:0]      ram_wr_addr;
   logic [ptc_pkg::SAMPLE_W-1:0]    ram_wr_data;
   logic                            ram_rd_en;
   logic [ptc_pkg::ADDR_W-1:0]      ram_rd_addr;
   logic [ptc_pkg::SAMPLE_W-1:0]    ram_rd_data;
   logic                            push;
   ptc_pkg::ptc_item_type           item;
   logic                            slot_free;

   assign csr_ready  = 1'b1;
   assign req_tready = slot_free;
   assign accept     = req_tvalid && slot_free;

   ptc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .accept      (accept),
      .sample      (req_tdata[ptc_pkg::SAMPLE_W-1:0]),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .push        (push),
      .item        (item)
   );

   ptc_ram #(
      .WIDTH (ptc_pkg::SAMPLE_W),
      .DEPTH (ptc_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .item        (item),
      .ram_rd_data (ram_rd_data),
      .slot_free   (slot_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // A request either writes the ring or reads it, never both
   assert property (@(posedge clock) disable iff (reset) !(ram_wr_en && ram_rd_en))
      else $error("ring written and read by the same request");

   // A drained stored sample never ends a run or a capture
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (!rsp_tlast && !rsp_tuser[1]))
      else $error("stored result flagged as last");

   // A live sample always ends its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("live result not flagged as last");

   // A drained stored sample is followed at once by its live sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tuser[0]) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("live result missing after stored result");

endmodule

`default_nettype wire
